>>> design/hex_text_speed_frame_parser_defines.svh
// Assertion macros shared by the hex text speed frame parser RTL.
`ifndef HEX_TEXT_SPEED_FRAME_PARSER_DEFINES_SVH
`define HEX_TEXT_SPEED_FRAME_PARSER_DEFINES_SVH

// Clocked check, switched off while the synchronous reset is asserted.
`define HFP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Clocked check that also holds through reset.
`define HFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

>>> design/hfp_pkg.sv
// Package: types, constants and result codes of the hex text speed frame parser.
`default_nettype none

package hfp_pkg;

    localparam int unsigned FRAME_BYTES      = 32;
    localparam int unsigned FRAME_BITS       = FRAME_BYTES * 8;
    localparam int unsigned DIGITS_PER_FRAME = FRAME_BYTES * 2;
    localparam int unsigned DCNT_W           = $clog2(DIGITS_PER_FRAME + 1);
    localparam int unsigned HEADER_BITS      = 64;
    localparam int unsigned CODE_W           = 3;
    localparam int unsigned OUT_DATA_W       = 192;

    localparam logic [CODE_W-1:0] RC_OK         = 3'd0;
    localparam logic [CODE_W-1:0] RC_NON_HEX    = 3'd1;
    localparam logic [CODE_W-1:0] RC_TOO_LONG   = 3'd2;
    localparam logic [CODE_W-1:0] RC_TOO_SHORT  = 3'd3;
    localparam logic [CODE_W-1:0] RC_BAD_HEADER = 3'd4;

    // Classification of one received character.
    typedef struct packed {
        logic       blank;
        logic       hex;
        logic [3:0] nibble;
    } char_class_t;

    // Frame assembler status seen by the result stage.
    typedef struct packed {
        logic              full;
        logic [CODE_W-1:0] err;
    } acc_status_t;

endpackage

`default_nettype wire

>>> design/hfp_char_class.sv
// Character classifier: whitespace detection and hex digit to nibble conversion.
`default_nettype none

module hfp_char_class
    import hfp_pkg::*;
(
    input  wire logic [7:0]  text_byte,
    output char_class_t      cls
);

    logic [7:0] diff;

    always_comb begin
        diff       = 8'h00;
        cls.blank  = (text_byte == 8'h20) || (text_byte inside {[8'h09:8'h0D]});
        cls.hex    = 1'b1;
        if (text_byte inside {[8'h30:8'h39]}) begin
            diff = text_byte - 8'h30;
        end else if (text_byte inside {[8'h61:8'h66]}) begin
            diff = text_byte - 8'h57;
        end else if (text_byte inside {[8'h41:8'h46]}) begin
            diff = text_byte - 8'h37;
        end else begin
            cls.hex = 1'b0;
        end
        cls.nibble = diff[3:0];
    end

endmodule

`default_nettype wire

>>> design/hfp_frame_acc.sv
// Frame assembler: digit counter, first-error latch and nibble shift register.
`default_nettype none
`include "hex_text_speed_frame_parser_defines.svh"

module hfp_frame_acc
    import hfp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_take,
    input  wire logic                  end_marker,
    input  wire char_class_t           cls,
    output logic [FRAME_BITS-1:0]      frame,
    output acc_status_t                status
);

    logic [DCNT_W-1:0]     digit_count_reg, digit_count_next;
    logic [CODE_W-1:0]     err_reg, err_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic                  full;

    assign full = (digit_count_reg == DCNT_W'(DIGITS_PER_FRAME));

    always_comb begin
        digit_count_next = digit_count_reg;
        err_next         = err_reg;
        frame_next       = frame_reg;
        if (item_take) begin
            if (end_marker) begin
                digit_count_next = '0;
                err_next         = RC_OK;
            end else if (err_reg == RC_OK && !cls.blank) begin
                if (!cls.hex) begin
                    err_next = RC_NON_HEX;
                end else if (full) begin
                    err_next = RC_TOO_LONG;
                end else begin
                    // shift in the nibble; byte 0 ends up in the top bits
                    frame_next       = {frame_reg[FRAME_BITS-5:0], cls.nibble};
                    digit_count_next = digit_count_reg + DCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= '0;
            err_reg         <= RC_OK;
        end else begin
            digit_count_reg <= digit_count_next;
            err_reg         <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign frame       = frame_reg;
    assign status.full = full;
    assign status.err  = err_reg;

    `HFP_ASSERT_CLK(a_end_clears, aclk, aresetn, (item_take && end_marker) |=> (digit_count_reg == '0 && err_reg == RC_OK), "end marker did not clear the assembler")
    `HFP_ASSERT_CLK(a_err_freezes, aclk, aresetn, (err_reg != RC_OK && !(item_take && end_marker)) |=> $stable(digit_count_reg), "digit count moved after an error")
    `HFP_ASSERT_CLK(a_count_bound, aclk, aresetn, (digit_count_reg <= DCNT_W'(DIGITS_PER_FRAME)), "digit count beyond one frame")

endmodule

`default_nettype wire

>>> design/hfp_result_out.sv
// Result stage: result code decision, field extraction and output register.
`default_nettype none
`include "hex_text_speed_frame_parser_defines.svh"

module hfp_result_out
    import hfp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire logic [FRAME_BITS-1:0]  frame,
    input  wire acc_status_t            status,
    input  wire logic [HEADER_BITS-1:0] header,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [CODE_W-1:0]           m_tuser,
    output logic [OUT_DATA_W-1:0]       m_tdata
);

    logic                  valid_reg, valid_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;

    always_comb begin
        if (status.err != RC_OK) begin
            code_next = status.err;
        end else if (!status.full) begin
            code_next = RC_TOO_SHORT;
        end else if (frame[FRAME_BITS-1 -: HEADER_BITS] != header) begin
            code_next = RC_BAD_HEADER;
        end else begin
            code_next = RC_OK;
        end

        // bytes 8..31 of the frame map in order onto the packed fields
        data_next = '0;
        if (code_next == RC_OK) begin
            data_next[31:0]    = frame[191:160];
            data_next[47:32]   = frame[159:144];
            data_next[63:48]   = frame[143:128];
            data_next[79:64]   = frame[127:112];
            data_next[95:80]   = frame[111:96];
            data_next[111:96]  = frame[95:80];
            data_next[159:112] = frame[79:32];
            data_next[191:160] = frame[31:0];
        end

        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= code_next;
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = code_reg;
    assign m_tdata  = data_reg;

    `HFP_ASSERT_CLK(a_err_zero, aclk, aresetn, (valid_reg && code_reg != RC_OK) |-> (data_reg == '0), "error result carries data")
    `HFP_ASSERT_CLK(a_load_shows, aclk, aresetn, load |=> valid_reg, "loaded result not presented")
    `HFP_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !valid_reg, "result valid straight after reset")

endmodule

`default_nettype wire

>>> design/hex_text_speed_frame_parser.sv
// Top level of the hex text speed frame parser.
//
// Usage:
//   s_ channel: one text character per transfer in s_tdata[7:0]; s_tlast high
//   marks the end of a payload (s_tdata is then ignored). Blanks are skipped,
//   hex digits of either case are packed into a 32-byte frame, high nibble
//   first. The first error of a payload (non-hex character, 65th digit, short
//   frame, header mismatch) decides the result code.
//   m_ channel: exactly one transfer per end marker. m_tuser holds the result
//   code; m_tdata holds the decoded fields, all zero for an error result.
//   cfg_wr_en / cfg_wr_data: writes the expected 64-bit header; write only
//   while the block is idle.
// Timing: one character is taken in every cycle while s_tready is high. An end
//   marker's result is in the output register in the cycle after its transfer.
// Stall: while a result waits on m_tready, s_tready stays low; it rises again
//   in the cycle the result is taken, so a ready sink sees no gap.
// Reset: synchronous active-low aresetn clears the digit count, error latch,
//   header register and output valid. Frame storage is not cleared.
`default_nettype none

module hex_text_speed_frame_parser
    import hfp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration
    input  wire logic                   cfg_wr_en,
    input  wire logic [HEADER_BITS-1:0] cfg_wr_data,    // expected_header
    // character input
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,        // [7:0] text_byte
    input  wire logic                   s_tlast,        // end_marker
    // result output
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [31:0] timestamp_seconds, [47:32] axle_speed_one, [63:48] axle_speed_two,
    // [79:64] axle_speed_three, [95:80] axle_speed_four, [111:96] ref_speed,
    // [159:112] status_bits, [191:160] frame_check_word
    output logic [OUT_DATA_W-1:0]       m_tdata,
    output logic [CODE_W-1:0]           m_tuser         // [2:0] result_code
);

    logic [HEADER_BITS-1:0] header_reg;
    logic                   item_take;
    logic                   end_take;
    char_class_t            cls;
    logic [FRAME_BITS-1:0]  frame;
    acc_status_t            status;

    // Holds expected header; user must write it only when idle, not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= '0;
        end else if (cfg_wr_en) begin
            header_reg <= cfg_wr_data;
        end
    end

    // Accept whenever the output register is empty or being drained this cycle.
    assign s_tready  = !m_tvalid || m_tready;
    assign item_take = s_tvalid && s_tready;
    assign end_take  = item_take && s_tlast;

    hfp_char_class u_class (
        .text_byte (s_tdata),
        .cls       (cls)
    );

    hfp_frame_acc u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_take  (item_take),
        .end_marker (s_tlast),
        .cls        (cls),
        .frame      (frame),
        .status     (status)
    );

    hfp_result_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (end_take),
        .frame    (frame),
        .status   (status),
        .header   (header_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
